// ----- design/kcl_pkg.sv -----
// Package: shared types and constants for the keypad code lock.
package kcl_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Event kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // Highest key index that names a real key (hash)
    localparam logic [3:0] KEY_MAX = 4'd11;

    // Result status codes
    localparam logic [2:0] ST_NONE         = 3'd0;
    localparam logic [2:0] ST_KEY_TAKEN    = 3'd1;
    localparam logic [2:0] ST_CORRECT      = 3'd2;
    localparam logic [2:0] ST_WRONG        = 3'd3;
    localparam logic [2:0] ST_ALARM        = 3'd4;
    localparam logic [2:0] ST_IGNORED      = 3'd5;
    localparam logic [2:0] ST_MANUAL_OPEN  = 3'd6;
    localparam logic [2:0] ST_LOCKOUT_OVER = 3'd7;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_OPEN  = 2'd1;
    localparam logic [1:0] PH_ALARM = 2'd2;
    localparam logic [1:0] PH_LOCK  = 2'd3;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_CODE_FIRST  = 3'd0;
    localparam logic [2:0] REG_CODE_SECOND = 3'd1;
    localparam logic [2:0] REG_CODE_THIRD  = 3'd2;
    localparam logic [2:0] REG_CODE_FOURTH = 3'd3;
    localparam logic [2:0] REG_MAX_WRONG   = 3'd4;
    localparam logic [2:0] REG_UNLOCK_SEC  = 3'd5;
    localparam logic [2:0] REG_ALARM_SEC   = 3'd6;
    localparam logic [2:0] REG_LOCKOUT_SEC = 3'd7;

    localparam logic [3:0] WRONG_SAT = 4'd15;
    localparam logic [1:0] LAST_KEY_SLOT = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] key_index;
    } kcl_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       lock_engaged;
        logic       buzzer_on;
        logic       alert_pulse;
        logic [2:0] keys_entered;
        logic [3:0] wrong_count;
        logic [7:0] seconds_left;
        logic [1:0] phase;
    } kcl_result_t;

    typedef struct packed {
        logic [3:0] code_key_first;
        logic [3:0] code_key_second;
        logic [3:0] code_key_third;
        logic [3:0] code_key_fourth;
        logic [3:0] max_wrong_codes;
        logic [7:0] unlock_seconds;
        logic [7:0] alarm_seconds;
        logic [7:0] lockout_seconds;
    } kcl_cfg_t;

endpackage

// ----- design/kcl_cfg_regs.sv -----
// Configuration register bank behind the APB-style port.
module kcl_cfg_regs
    import kcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output kcl_cfg_t          cfg
);

    kcl_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_key_first  <= 4'd0;
            cfg_reg.code_key_second <= 4'd1;
            cfg_reg.code_key_third  <= 4'd2;
            cfg_reg.code_key_fourth <= 4'd11;
            cfg_reg.max_wrong_codes <= 4'd3;
            cfg_reg.unlock_seconds  <= 8'd5;
            cfg_reg.alarm_seconds   <= 8'd5;
            cfg_reg.lockout_seconds <= 8'd60;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_CODE_FIRST:  cfg_reg.code_key_first  <= pwdata[3:0];
                REG_CODE_SECOND: cfg_reg.code_key_second <= pwdata[3:0];
                REG_CODE_THIRD:  cfg_reg.code_key_third  <= pwdata[3:0];
                REG_CODE_FOURTH: cfg_reg.code_key_fourth <= pwdata[3:0];
                REG_MAX_WRONG:   cfg_reg.max_wrong_codes <= pwdata[3:0];
                REG_UNLOCK_SEC:  cfg_reg.unlock_seconds  <= pwdata[7:0];
                REG_ALARM_SEC:   cfg_reg.alarm_seconds   <= pwdata[7:0];
                REG_LOCKOUT_SEC: cfg_reg.lockout_seconds <= pwdata[7:0];
                default:         cfg_reg.code_key_first  <= cfg_reg.code_key_first;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CODE_FIRST:  prdata = {28'd0, cfg_reg.code_key_first};
            REG_CODE_SECOND: prdata = {28'd0, cfg_reg.code_key_second};
            REG_CODE_THIRD:  prdata = {28'd0, cfg_reg.code_key_third};
            REG_CODE_FOURTH: prdata = {28'd0, cfg_reg.code_key_fourth};
            REG_MAX_WRONG:   prdata = {28'd0, cfg_reg.max_wrong_codes};
            REG_UNLOCK_SEC:  prdata = {24'd0, cfg_reg.unlock_seconds};
            REG_ALARM_SEC:   prdata = {24'd0, cfg_reg.alarm_seconds};
            REG_LOCKOUT_SEC: prdata = {24'd0, cfg_reg.lockout_seconds};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- design/kcl_core.sv -----
// Lock state and single-pass event update logic.
module kcl_core
    import kcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  kcl_item_t   item,
    input  kcl_cfg_t    cfg,
    output kcl_result_t result
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] key_count_reg;
    logic [1:0] key_count_next;
    logic [3:0] wrong_total_reg;
    logic [3:0] wrong_total_next;
    logic [7:0] seconds_reg;
    logic [7:0] seconds_next;
    logic [3:0] keys_reg [3];

    logic [2:0] status;
    logic       beep;
    logic       alert;
    logic       match;
    logic       key_store;
    logic [3:0] wrong_inc;
    logic [7:0] seconds_dec;

    always_comb
    begin
        phase_next       = phase_reg;
        key_count_next   = key_count_reg;
        wrong_total_next = wrong_total_reg;
        seconds_next     = seconds_reg;
        status           = ST_NONE;
        beep             = 1'b0;
        alert            = 1'b0;
        key_store        = 1'b0;
        match            = (keys_reg[0] == cfg.code_key_first)
                        && (keys_reg[1] == cfg.code_key_second)
                        && (keys_reg[2] == cfg.code_key_third)
                        && (item.key_index == cfg.code_key_fourth);
        wrong_inc        = (wrong_total_reg == WRONG_SAT) ? WRONG_SAT
                                                         : wrong_total_reg + 4'd1;
        seconds_dec      = (seconds_reg == 8'd0) ? 8'd0 : seconds_reg - 8'd1;

        case (item.kind)
            KIND_KEY:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    status = ST_IGNORED;
                end
                else if (item.key_index <= KEY_MAX)
                begin
                    status = ST_KEY_TAKEN;
                    if (key_count_reg == LAST_KEY_SLOT)
                    begin
                        key_count_next = 2'd0;
                        if (match)
                        begin
                            status           = ST_CORRECT;
                            wrong_total_next = 4'd0;
                            phase_next       = PH_OPEN;
                            seconds_next     = cfg.unlock_seconds;
                        end
                        else
                        begin
                            status           = ST_WRONG;
                            wrong_total_next = wrong_inc;
                            if (wrong_inc >= cfg.max_wrong_codes)
                            begin
                                status       = ST_ALARM;
                                phase_next   = PH_ALARM;
                                seconds_next = cfg.alarm_seconds;
                            end
                        end
                    end
                    else
                    begin
                        key_store      = 1'b1;
                        key_count_next = key_count_reg + 2'd1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    seconds_next = seconds_dec;
                    beep         = (phase_reg == PH_LOCK);
                    if (seconds_dec == 8'd0)
                    begin
                        case (phase_reg)
                            PH_OPEN:
                            begin
                                phase_next = PH_IDLE;
                            end
                            PH_ALARM:
                            begin
                                alert        = 1'b1;
                                phase_next   = PH_LOCK;
                                seconds_next = cfg.lockout_seconds;
                            end
                            PH_LOCK:
                            begin
                                phase_next       = PH_IDLE;
                                wrong_total_next = 4'd0;
                                status           = ST_LOCKOUT_OVER;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            KIND_BUTTON:
            begin
                if (phase_reg inside {PH_IDLE, PH_OPEN})
                begin
                    phase_next   = PH_OPEN;
                    seconds_next = cfg.unlock_seconds;
                    status       = ST_MANUAL_OPEN;
                end
                else
                begin
                    status = ST_IGNORED;
                end
            end
            default:
            begin
                status = ST_NONE;
            end
        endcase

        if (phase_next == PH_ALARM)
        begin
            beep = 1'b1;
        end

        result.status       = status;
        result.lock_engaged = (phase_next != PH_OPEN);
        result.buzzer_on    = beep;
        result.alert_pulse  = alert;
        result.keys_entered = {1'b0, key_count_next};
        result.wrong_count  = wrong_total_next;
        result.seconds_left = seconds_next;
        result.phase        = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            key_count_reg   <= 2'd0;
            wrong_total_reg <= 4'd0;
            seconds_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            key_count_reg   <= key_count_next;
            wrong_total_reg <= wrong_total_next;
            seconds_reg     <= seconds_next;
        end
    end

    // Collected keys: only the first three are stored, the fourth compares live
    always_ff @(posedge clk)
    begin
        if (step && key_store)
        begin
            keys_reg[key_count_reg] <= item.key_index;
        end
    end

    a_idle_no_seconds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> seconds_reg == 8'd0)
        else $error("seconds counter nonzero while idle");

    a_busy_key_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == KIND_KEY && phase_reg != PH_IDLE
        |=> $stable(key_count_reg) && $stable(wrong_total_reg) && $stable(phase_reg))
        else $error("key changed state while busy");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(seconds_reg) && $stable(key_count_reg))
        else $error("state moved without an item");

    a_alert_enters_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        result.alert_pulse |-> result.phase == PH_LOCK && phase_reg == PH_ALARM)
        else $error("alert outside alarm-to-lockout handover");

endmodule

// ----- design/keypad_code_lock_with_lockout_top.sv -----
// Top level of the four-key code lock: handshake staging, core and register bank.
//
//  channel  | signals                              | direction | payload
//  ---------+--------------------------------------+-----------+--------------
//  item     | item_valid / item_ready / item       | in        | kcl_item_t
//  result   | result_valid / result_ready / result | out       | kcl_result_t
//  config   | psel penable pwrite paddr pwdata ... | in/out    | 32-bit APB
//
// Each transaction passes through the input register and then the result
// register; one transaction per cycle is taken while the result is not stalled.
// The state update in kcl_core sets the rate; nothing iterates.
// Reset (rst_n low, asynchronous) empties both stages, sets the phase to idle,
// clears key, wrong and seconds counts and loads register defaults.
// A stalled result holds the result register; the input register still takes
// one more transaction, then item_ready drops until the result moves on.
module keypad_code_lock_with_lockout_top
    import kcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  kcl_item_t         item,
    output logic              result_valid,
    input  logic              result_ready,
    output kcl_result_t       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic        item_valid_reg;
    kcl_item_t   item_reg;
    logic        result_valid_reg;
    kcl_result_t result_reg;
    kcl_result_t core_result;
    kcl_cfg_t    cfg;
    logic        advance;
    logic        step;

    // Result stage can take a new value when empty or being drained
    assign advance    = !result_valid_reg || result_ready;
    // Apply the buffered transaction to the lock state when it moves forward
    assign step       = item_valid_reg && advance;
    // Input stage frees up when empty or when its transaction moves on
    assign item_ready = !item_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    kcl_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Stage control: load on accept, drop when the transaction moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

endmodule
